// ===== rtl/tpm_pkg.sv =====
// Shared types, constants and helpers of the thermal protection monitor.
// Used by every module under rtl/; depends on nothing else.
package tpm_pkg;

  localparam int DATA_W     = 9;
  localparam int GRADE_W    = 2;
  localparam int STATUS_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int WINDOW_DEF = 10;

  typedef logic signed [DATA_W-1:0] temp_t;
  typedef logic [GRADE_W-1:0]       grade_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // register indexes on the config port
  localparam cfg_idx_t REG_BOARD_WARN  = 3'd0;
  localparam cfg_idx_t REG_BOARD_LIMIT = 3'd1;
  localparam cfg_idx_t REG_BOARD_FAIL  = 3'd2;
  localparam cfg_idx_t REG_MOTOR_WARN  = 3'd3;
  localparam cfg_idx_t REG_MOTOR_LIMIT = 3'd4;
  localparam cfg_idx_t REG_MOTOR_FAIL  = 3'd5;

  localparam temp_t BOARD_WARN_RST  = 9'sd85;
  localparam temp_t BOARD_LIMIT_RST = 9'sd90;
  localparam temp_t BOARD_FAIL_RST  = 9'sd100;
  localparam temp_t MOTOR_WARN_RST  = 9'sd90;
  localparam temp_t MOTOR_LIMIT_RST = 9'sd100;
  localparam temp_t MOTOR_FAIL_RST  = 9'sd110;

  localparam grade_t GRADE_OK    = 2'd0;
  localparam grade_t GRADE_WARN  = 2'd1;
  localparam grade_t GRADE_LIMIT = 2'd2;
  localparam grade_t GRADE_FAIL  = 2'd3;

  // Gray-style status codes per grade
  localparam grade_t CODE_OK    = 2'b00;
  localparam grade_t CODE_WARN  = 2'b01;
  localparam grade_t CODE_LIMIT = 2'b11;
  localparam grade_t CODE_FAIL  = 2'b10;

  typedef struct packed {
    temp_t warn;
    temp_t limit;
    temp_t fail;
  } tpm_thr_t;

  // pipeline advance controls from the top level
  typedef struct packed {
    logic accept;   // input word taken: shift cells, update sum
    logic s2_en;    // load reciprocal-multiply stage
    logic s3_en;    // load correction stage
    logic s4_en;    // load output registers
    logic s4_fire;  // a valid word enters the output registers
  } tpm_ctl_t;

  function automatic grade_t code_of(input grade_t g);
    grade_t c;
    case (g)
      GRADE_OK:    c = CODE_OK;
      GRADE_WARN:  c = CODE_WARN;
      GRADE_LIMIT: c = CODE_LIMIT;
      GRADE_FAIL:  c = CODE_FAIL;
      default:     c = CODE_OK;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/tpm_tap_cell.sv =====
// One cell of the sample delay chain: holds one sample, passes it on.
// Depends on tpm_pkg.
module tpm_tap_cell
  import tpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift,
  input  temp_t d,
  output temp_t q
);

  temp_t smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
    end else if (shift) begin
      smp_r <= d;
    end
  end

  assign q = smp_r;

endmodule

// ===== rtl/tpm_channel.sv =====
// One temperature channel: chain of tap cells, running sum, divide by WINDOW.
// Depends on tpm_pkg and tpm_tap_cell.
module tpm_channel
  import tpm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  tpm_ctl_t ctl,
  input  temp_t    sample,
  output temp_t    average
);

  localparam int MAG_W  = $clog2((2 ** (DATA_W - 1)) * WINDOW + 1);
  localparam int SUM_W  = MAG_W + 1;
  localparam int PROD_W = 2 * MAG_W;
  localparam logic [MAG_W-1:0] RECIP = MAG_W'((1 << MAG_W) / WINDOW);
  localparam logic [MAG_W-1:0] WIN_M = MAG_W'(WINDOW);

  temp_t tap [WINDOW+1];

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SUM_W-1:0] p1_sum_r;
  logic signed [SUM_W-1:0] mag_full;
  logic [MAG_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [MAG_W-1:0]        p2_qest_r, p2_mag_r;
  logic                    p2_neg_r;
  logic [MAG_W-1:0]        qw, rem, q;
  logic signed [DATA_W:0]  sq, avg_w;
  temp_t                   p3_avg_r;

  assign tap[0] = sample;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    tpm_tap_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ctl.accept),
      .d     (tap[i]),
      .q     (tap[i+1])
    );
  end

  // oldest sample leaves the window as the new one enters
  assign sum_nxt = sum_r - SUM_W'(tap[WINDOW]) + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.accept) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      p1_sum_r <= sum_nxt;
    end
  end

  // |sum| * floor(2^MAG_W / WINDOW): estimate is exact or one short
  assign mag_full = p1_sum_r[SUM_W-1] ? -p1_sum_r : p1_sum_r;
  assign mag      = mag_full[MAG_W-1:0];
  assign prod     = PROD_W'(mag) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      p2_qest_r <= prod[PROD_W-1:MAG_W];
      p2_mag_r  <= mag;
      p2_neg_r  <= p1_sum_r[SUM_W-1];
    end
  end

  assign qw    = p2_qest_r * WIN_M;
  assign rem   = p2_mag_r - qw;
  assign q     = (rem >= WIN_M) ? p2_qest_r + MAG_W'(1) : p2_qest_r;
  assign sq    = {1'b0, q[DATA_W-1:0]};
  assign avg_w = p2_neg_r ? -sq : sq;   // truncation toward zero

  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      p3_avg_r <= avg_w[DATA_W-1:0];
    end
  end

  assign average = p3_avg_r;

endmodule

// ===== rtl/tpm_grade.sv =====
// Grading, fault code with hysteresis and status packing; output registers.
// Depends on tpm_pkg.
module tpm_grade
  import tpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  tpm_ctl_t ctl,
  input  tpm_thr_t board_thr,
  input  tpm_thr_t motor_thr,
  input  temp_t    board_avg,
  input  temp_t    motor_one_avg,
  input  temp_t    motor_two_avg,
  output temp_t    board_average,
  output temp_t    motor_one_average,
  output temp_t    motor_two_average,
  output grade_t   board_grade,
  output grade_t   motor_one_grade,
  output grade_t   motor_two_grade,
  output grade_t   fault_code,
  output status_t  motor_one_status,
  output status_t  motor_two_status
);

  function automatic grade_t grade_of(input temp_t avg, input tpm_thr_t thr);
    grade_t g;
    if (avg > thr.fail) begin
      g = GRADE_FAIL;
    end else if (avg > thr.limit) begin
      g = GRADE_LIMIT;
    end else if (avg > thr.warn) begin
      g = GRADE_WARN;
    end else begin
      g = GRADE_OK;
    end
    return g;
  endfunction

  grade_t  gb, g1, g2, worst01, worst, fault;
  logic    high_hold_r, high_hold_nxt;
  temp_t   b_avg_r, m1_avg_r, m2_avg_r;
  grade_t  gb_r, g1_r, g2_r, fault_r;
  status_t st1_r, st2_r;

  assign gb      = grade_of(board_avg, board_thr);
  assign g1      = grade_of(motor_one_avg, motor_thr);
  assign g2      = grade_of(motor_two_avg, motor_thr);
  assign worst01 = (g1 > gb) ? g1 : gb;
  assign worst   = (g2 > worst01) ? g2 : worst01;

  always_comb begin
    high_hold_nxt = high_hold_r;
    case (worst)
      GRADE_LIMIT, GRADE_FAIL: begin
        fault         = worst;
        high_hold_nxt = 1'b1;
      end
      GRADE_WARN: begin
        fault = high_hold_r ? GRADE_LIMIT : GRADE_WARN;
      end
      default: begin
        fault         = GRADE_OK;
        high_hold_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_hold_r <= 1'b0;
    end else if (ctl.s4_fire) begin
      high_hold_r <= high_hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s4_en) begin
      b_avg_r  <= board_avg;
      m1_avg_r <= motor_one_avg;
      m2_avg_r <= motor_two_avg;
      gb_r     <= gb;
      g1_r     <= g1;
      g2_r     <= g2;
      fault_r  <= fault;
      st1_r    <= {code_of(gb), code_of(g1)};
      st2_r    <= {code_of(gb), code_of(g2)};
    end
  end

  assign board_average     = b_avg_r;
  assign motor_one_average = m1_avg_r;
  assign motor_two_average = m2_avg_r;
  assign board_grade       = gb_r;
  assign motor_one_grade   = g1_r;
  assign motor_two_grade   = g2_r;
  assign fault_code        = fault_r;
  assign motor_one_status  = st1_r;
  assign motor_two_status  = st2_r;

endmodule

// ===== rtl/thermal_protection_monitor_core.sv =====
// Thermal protection monitor, top level: pipeline control, threshold registers.
// Depends on tpm_pkg, tpm_channel (with tpm_tap_cell) and tpm_grade.
//
// Usage:
//  - Input channel (in_valid / in_stall): one word is one set of three
//    temperatures (board, motor 1, motor 2), 9-bit signed degrees C.
//  - Result channel (out_valid / out_stall): one word per input word with
//    the three WINDOW-sample moving averages, their grades, fault code and
//    the two packed motor status nibbles.
//  - Config channel (cfg_valid / cfg_ready): threshold writes by index,
//    always ready; indexes beyond the six thresholds are dropped. Write
//    only while the block holds no word in flight.
//  - Four register stages (sum update at the accepting edge, reciprocal
//    multiply, quotient correction, grading) lead to out_valid. Throughput:
//    one word per cycle while the result channel is not stalled.
//  - A stalled result holds in the output register; empty stages upstream
//    keep filling, so in_stall rises only once every stage holds a word.
//  - Reset: tap chains and running sums cleared (warm-up averages include
//    zeros), hysteresis flag cleared, thresholds back to their defaults.
module thermal_protection_monitor_core
  import tpm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
)
(
  input  logic     clk,
  input  logic     rst_n,
  // input words
  input  logic     in_valid,
  output logic     in_stall,
  input  temp_t    in_board_sample,
  input  temp_t    in_motor_one_sample,
  input  temp_t    in_motor_two_sample,
  // result words
  output logic     out_valid,
  input  logic     out_stall,
  output temp_t    out_board_average,
  output temp_t    out_motor_one_average,
  output temp_t    out_motor_two_average,
  output grade_t   out_board_grade,
  output grade_t   out_motor_one_grade,
  output grade_t   out_motor_two_grade,
  output grade_t   out_fault_code,
  output status_t  out_motor_one_status,
  output status_t  out_motor_two_status,
  // threshold writes
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  temp_t    cfg_data
);

  tpm_thr_t board_thr_r, motor_thr_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  tpm_ctl_t ctl;

  temp_t b_avg, m1_avg, m2_avg;

  // ---- threshold registers ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_thr_r <= '{warn: BOARD_WARN_RST, limit: BOARD_LIMIT_RST, fail: BOARD_FAIL_RST};
      motor_thr_r <= '{warn: MOTOR_WARN_RST, limit: MOTOR_LIMIT_RST, fail: MOTOR_FAIL_RST};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOARD_WARN:  board_thr_r.warn  <= cfg_data;
        REG_BOARD_LIMIT: board_thr_r.limit <= cfg_data;
        REG_BOARD_FAIL:  board_thr_r.fail  <= cfg_data;
        REG_MOTOR_WARN:  motor_thr_r.warn  <= cfg_data;
        REG_MOTOR_LIMIT: motor_thr_r.limit <= cfg_data;
        REG_MOTOR_FAIL:  motor_thr_r.fail  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- pipeline flow: a stage takes a word when empty or emptying ----
  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_stall = !rdy1;
  assign out_valid = v4_r;

  assign ctl.accept  = in_valid && rdy1;
  assign ctl.s2_en   = rdy2;
  assign ctl.s3_en   = rdy3;
  assign ctl.s4_en   = rdy4;
  assign ctl.s4_fire = rdy4 && v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // ---- averaging channels ----
  tpm_channel #(.WINDOW(WINDOW)) u_board (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sample  (in_board_sample),
    .average (b_avg)
  );

  tpm_channel #(.WINDOW(WINDOW)) u_motor_one (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sample  (in_motor_one_sample),
    .average (m1_avg)
  );

  tpm_channel #(.WINDOW(WINDOW)) u_motor_two (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sample  (in_motor_two_sample),
    .average (m2_avg)
  );

  // ---- grading and output registers ----
  tpm_grade u_grade (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .board_thr         (board_thr_r),
    .motor_thr         (motor_thr_r),
    .board_avg         (b_avg),
    .motor_one_avg     (m1_avg),
    .motor_two_avg     (m2_avg),
    .board_average     (out_board_average),
    .motor_one_average (out_motor_one_average),
    .motor_two_average (out_motor_two_average),
    .board_grade       (out_board_grade),
    .motor_one_grade   (out_motor_one_grade),
    .motor_two_grade   (out_motor_two_grade),
    .fault_code        (out_fault_code),
    .motor_one_status  (out_motor_one_status),
    .motor_two_status  (out_motor_two_status)
  );

endmodule
